[design/spq_pkg.sv]
// ---------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Operation codes, result status codes, parameter defaults and the command
// struct that the top level broadcasts to every slot cell.
// ---------------------------------------------------------------------------
package spq_pkg;

    // parameter defaults
    localparam int DEFAULT_CAPACITY      = 16;
    localparam int DEFAULT_PRIORITY_BITS = 8;

    // payload widths fixed by the interface
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // command broadcast to every cell
    typedef struct packed {
        logic enq;  // insert the new entry, shift the tail back by one
        logic deq;  // remove the head, shift everything forward by one
    } t_cmd;

endpackage

[design/spq_cell.sv]
// ---------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one value and priority. On insert it keeps its entry, takes the new
// entry or takes its left neighbor's entry; on removal it takes its right
// neighbor's entry.
// ---------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int IDX      = 0,
    parameter int PRIO_W   = DEFAULT_PRIORITY_BITS,
    parameter int CNT_W    = 5
) (
    input  logic                i_clk,
    input  t_cmd                i_cmd,
    input  logic [CNT_W-1:0]    i_count,
    input  logic [VALUE_W-1:0]  i_new_value,
    input  logic [PRIO_W-1:0]   i_new_prio,
    input  logic                i_left_open,
    input  logic [VALUE_W-1:0]  i_left_value,
    input  logic [PRIO_W-1:0]   i_left_prio,
    input  logic [VALUE_W-1:0]  i_right_value,
    input  logic [PRIO_W-1:0]   i_right_prio,
    output logic                o_open,
    output logic [VALUE_W-1:0]  o_value,
    output logic [PRIO_W-1:0]   o_prio,
    output logic [VALUE_W-1:0]  o_next_value
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [VALUE_W-1:0] r_value;
    logic [PRIO_W-1:0]  r_prio;
    logic [VALUE_W-1:0] n_value;
    logic [PRIO_W-1:0]  n_prio;
    logic               w_occupied;

    // slot is open to the new entry when empty or of strictly lower priority
    assign w_occupied = (IDX_C < i_count);
    assign o_open     = !w_occupied || (r_prio < i_new_prio);

    // next contents
    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_cmd.deq) begin
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end else if (i_cmd.enq && o_open) begin
            if (i_left_open) begin
                n_value = i_left_value;
                n_prio  = i_left_prio;
            end else begin
                n_value = i_new_value;
                n_prio  = i_new_prio;
            end
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_value      = r_value;
    assign o_prio       = r_prio;
    assign o_next_value = n_value;

endmodule

[design/sorted_priority_queue_top.sv]
// ---------------------------------------------------------------------------
// sorted_priority_queue_top: bounded priority queue in a chain of slot cells
// Entries stay sorted by priority, highest at slot 0, equal priorities in
// arrival order. Every slot compares against the new entry at once and
// shifts with its neighbors.
//
//   channel | ports                                         | dir
//   --------+-----------------------------------------------+-----
//   in      | i_in_valid o_in_ready i_op i_item_value       | in
//           | i_item_priority                               |
//   out     | o_out_valid i_out_ready o_taken_value         | out
//           | o_status o_front_value o_front_valid          |
//           | o_fill_level                                  |
//
// One transaction per cycle while each result is taken: the slot chain updates at
// the accepting edge and the result is in the output register in the next cycle.
// The output register lets a new transaction in while the result is taken.
// A stalled result holds the input off until i_out_ready is seen.
// Synchronous active-low reset empties the queue; slot contents are not
// cleared, only the fill count and the output valid flag.
// ---------------------------------------------------------------------------
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY      = DEFAULT_CAPACITY,
    parameter int PRIORITY_BITS = DEFAULT_PRIORITY_BITS,
    localparam int CNT_W        = $clog2(CAPACITY + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_op,
    input  logic [VALUE_W-1:0]       i_item_value,
    input  logic [PRIORITY_BITS-1:0] i_item_priority,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [VALUE_W-1:0]       o_taken_value,
    output logic [STATUS_W-1:0]      o_status,
    output logic [VALUE_W-1:0]       o_front_value,
    output logic                     o_front_valid,
    output logic [CNT_W-1:0]         o_fill_level
);

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic                     r_out_valid;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [VALUE_W-1:0]       r_taken_value;
    logic [STATUS_W-1:0]      r_status;
    logic [VALUE_W-1:0]       r_front_value;
    logic                     r_front_valid;
    logic [CNT_W-1:0]         r_fill_level;

    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    t_cmd                     w_cmd;
    logic [STATUS_W-1:0]      w_status;

    logic                     w_open  [CAPACITY];
    logic [VALUE_W-1:0]       w_value [CAPACITY];
    logic [PRIORITY_BITS-1:0] w_prio  [CAPACITY];
    logic [VALUE_W-1:0]       w_next  [CAPACITY];

    // handshake and command decode
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CAP_C);
    assign w_empty    = (r_count == '0);
    assign w_cmd.enq  = w_accept && (i_op == OP_ENQUEUE) && !w_full;
    assign w_cmd.deq  = w_accept && (i_op == OP_DEQUEUE) && !w_empty;

    always_comb begin
        n_count = r_count;
        if (w_cmd.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.deq) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        w_status = STATUS_DONE;
        if (w_accept && (i_op == OP_DEQUEUE) && w_empty) begin
            w_status = STATUS_EMPTY;
        end else if (w_accept && (i_op == OP_ENQUEUE) && w_full) begin
            w_status = STATUS_FULL;
        end
    end

    // chain of slot cells, slot 0 is the head
    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        logic                     w_l_open;
        logic [VALUE_W-1:0]       w_l_value;
        logic [PRIORITY_BITS-1:0] w_l_prio;
        logic [VALUE_W-1:0]       w_r_value;
        logic [PRIORITY_BITS-1:0] w_r_prio;

        if (g == 0) begin : g_head
            assign w_l_open  = 1'b0;
            assign w_l_value = i_item_value;
            assign w_l_prio  = i_item_priority;
        end else begin : g_mid
            assign w_l_open  = w_open[g-1];
            assign w_l_value = w_value[g-1];
            assign w_l_prio  = w_prio[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_r_value = '0;
            assign w_r_prio  = '0;
        end else begin : g_body
            assign w_r_value = w_value[g+1];
            assign w_r_prio  = w_prio[g+1];
        end

        spq_cell #(
            .IDX    (g),
            .PRIO_W (PRIORITY_BITS),
            .CNT_W  (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_count       (r_count),
            .i_new_value   (i_item_value),
            .i_new_prio    (i_item_priority),
            .i_left_open   (w_l_open),
            .i_left_value  (w_l_value),
            .i_left_prio   (w_l_prio),
            .i_right_value (w_r_value),
            .i_right_prio  (w_r_prio),
            .o_open        (w_open[g]),
            .o_value       (w_value[g]),
            .o_prio        (w_prio[g]),
            .o_next_value  (w_next[g])
        );
    end

    // fill count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_taken_value <= w_cmd.deq ? w_value[0] : '0;
            r_status      <= w_status;
            r_front_value <= (n_count != '0) ? w_next[0] : '0;
            r_front_valid <= (n_count != '0);
            r_fill_level  <= n_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_taken_value = r_taken_value;
    assign o_status      = r_status;
    assign o_front_value = r_front_value;
    assign o_front_valid = r_front_valid;
    assign o_fill_level  = r_fill_level;

    // fill count stays within capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("fill count above capacity");

    // head two slots stay in priority order
    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_prio[0] >= w_prio[1]))
        else $error("head slots out of priority order");

    // dropped enqueue leaves the count unchanged and is flagged
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == OP_ENQUEUE) && w_full)
        |=> (o_status == STATUS_FULL) && (r_count == $past(r_count)))
        else $error("enqueue on full queue not dropped");

    // successful dequeue shrinks the queue by one
    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.deq |=> (r_count == $past(r_count) - CNT_W'(1))
        && (o_fill_level == r_count))
        else $error("dequeue count mismatch");

    // reported head flag agrees with reported fill level
    a_front_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_front_valid == (o_fill_level != '0)))
        else $error("front valid inconsistent with fill level");

endmodule
